[src/kbrd_pkg.sv]
`default_nettype none
package kbrd_pkg;

	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIAS_ALPHA = 3'd0,
		REG_SIGNAL_GAIN = 3'd1,
		REG_BP_B0 = 3'd2,
		REG_BP_A1 = 3'd3,
		REG_BP_A2 = 3'd4,
		REG_ENV_ALPHA = 3'd5,
		REG_RMS_ALPHA = 3'd6
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] BIAS_ALPHA_RST = 16'd655;
	localparam logic [CFG_W-1:0] SIGNAL_GAIN_RST = 16'd2048;
	localparam logic [CFG_W-1:0] ENV_ALPHA_RST = 16'd6554;
	localparam logic [CFG_W-1:0] RMS_ALPHA_RST = 16'd3277;

	localparam int SIG_W = 24;
	localparam int OUT_W = 23;
	localparam int DLY_W = 32;
	localparam int MS_W = 48;
	localparam int ROOT_W = 24;
	localparam int ROOT_STEPS = MS_W / 2;

	// wide working accumulator
	localparam int ACC_W = 72;
	typedef logic signed [ACC_W-1:0] acc_t;

	// floor((v + 2^(s-1)) / 2^s)
	function automatic acc_t rnd_shift(input acc_t v, input int unsigned s);
		acc_t t;
		t = v + (acc_t'(1) <<< (s - 1));
		return t >>> s;
	endfunction

	function automatic acc_t sat_val(input acc_t v, input int unsigned w);
		acc_t hi;
		acc_t lo;
		hi = (acc_t'(1) <<< (w - 1)) - acc_t'(1);
		lo = -(acc_t'(1) <<< (w - 1));
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

[src/knock_bandpass_rms_detector.sv]
// Knock sensor detector: one converter sample in, one result (bandpass sample, envelope
// level, rms level) out. One shared signed multiplier (about 34 x 33 bits) runs under a
// small sequencer, followed by a square root that resolves one result bit per cycle.
// A request runs the multiply steps (bias, gain, filter output and delays, envelope,
// mean square in a low and a high half), then the root steps. The result is held
// while out_stall is high. A request is taken only in the idle state after the result
// has been handed on, so no new sample is taken before the last is done. The user must
// write configuration registers only while the block is idle; it does not enforce this.
`default_nettype none
module knock_bandpass_rms_detector import kbrd_pkg::*; #(
	parameter int SAMPLE_BITS = 12,
	parameter int FRAC_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [SAMPLE_BITS-1:0] adc_sample,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [SIG_W-1:0] bandpass_sample,
	output logic [OUT_W-1:0] envelope_level,
	output logic [OUT_W-1:0] rms_level
);

	localparam int BIAS_W = SAMPLE_BITS + 16;

	typedef enum logic [3:0] {
		ST_IDLE, ST_BIAS, ST_GAIN, ST_Y, ST_D1A, ST_D2A, ST_D2B, ST_ENV, ST_MSL, ST_MSH,
		ST_ROOT, ST_OUT
	} state_t;

	state_t state_q;
	logic [CFG_W-1:0] bias_alpha_q, signal_gain_q, b0_q, a1_q, a2_q, env_alpha_q, rms_alpha_q;
	logic [BIAS_W-1:0] bias_q;
	logic signed [DLY_W-1:0] d1_q, d2_q;
	logic [SIG_W-1:0] env_q;
	logic [MS_W-1:0] ms_q;
	logic signed [SIG_W-1:0] c_q, y_q;
	logic [SAMPLE_BITS-1:0] x_q;
	acc_t part_q;
	acc_t lo_q;
	logic [MS_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [4:0] cnt_q;

	// shared multiplier operands
	logic signed [33:0] op_a;
	logic signed [32:0] op_b;
	acc_t prod;
	acc_t xs, t, ay, e;
	logic [MS_W+1:0] trial;
	logic [MS_W-1:0] rem_sh;
	logic [4:0] sh;

	assign xs = acc_t'({1'b0, x_q}) <<< 16;
	assign ay = y_q[SIG_W-1] ? -acc_t'(y_q) : acc_t'(y_q);
	assign e = acc_t'(y_q) * acc_t'(y_q);

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_BIAS: begin
				op_a = 34'(signed'({1'b0, bias_alpha_q}));
				op_b = 33'(xs - acc_t'({1'b0, bias_q}));
			end
			ST_GAIN: begin
				op_a = 34'(signed'({1'b0, signal_gain_q}));
				op_b = 33'(xs - acc_t'({1'b0, bias_q}));
			end
			ST_Y: begin
				op_a = 34'(signed'(b0_q));
				op_b = 33'(c_q);
			end
			ST_D1A: begin
				op_a = -34'(signed'(a1_q));
				op_b = 33'(y_q);
			end
			ST_D2A: begin
				op_a = -34'(signed'(b0_q));
				op_b = 33'(c_q);
			end
			ST_D2B: begin
				op_a = -34'(signed'(a2_q));
				op_b = 33'(y_q);
			end
			ST_ENV: begin
				op_a = 34'(signed'({1'b0, env_alpha_q}));
				op_b = 33'(ay - acc_t'({1'b0, env_q}));
			end
			ST_MSL: begin
				op_a = 34'(signed'({1'b0, rms_alpha_q}));
				op_b = 33'({1'b0, part_q[23:0]});
			end
			ST_MSH: begin
				op_a = 34'(signed'({1'b0, rms_alpha_q}));
				op_b = 33'(part_q >>> 24);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod = acc_t'(op_a) * acc_t'(op_b);
	assign t = acc_t'({1'b0, ms_q});
	assign sh = cnt_q;
	assign rem_sh = rem_q;
	assign trial = {2'b00, rem_sh} - ((MS_W+2)'({root_q, 2'b01}) << (2 * sh));

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign bandpass_sample = y_q;
	assign envelope_level = env_q[SIG_W-1] ? {OUT_W{1'b1}} : env_q[OUT_W-1:0];
	assign rms_level = root_q[ROOT_W-1] ? {OUT_W{1'b1}} : root_q[OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		acc_t v;
		acc_t m;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bias_alpha_q <= BIAS_ALPHA_RST;
			signal_gain_q <= SIGNAL_GAIN_RST;
			b0_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
			env_alpha_q <= ENV_ALPHA_RST;
			rms_alpha_q <= RMS_ALPHA_RST;
			bias_q <= '0;
			d1_q <= '0;
			d2_q <= '0;
			env_q <= '0;
			ms_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BIAS_ALPHA: bias_alpha_q <= cfg_data;
					REG_SIGNAL_GAIN: signal_gain_q <= cfg_data;
					REG_BP_B0: b0_q <= cfg_data;
					REG_BP_A1: a1_q <= cfg_data;
					REG_BP_A2: a2_q <= cfg_data;
					REG_ENV_ALPHA: env_alpha_q <= cfg_data;
					REG_RMS_ALPHA: rms_alpha_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						x_q <= adc_sample;
						state_q <= ST_BIAS;
					end
				end
				ST_BIAS: begin
					bias_q <= BIAS_W'(acc_t'({1'b0, bias_q}) + rnd_shift(prod, 16));
					state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					c_q <= SIG_W'(sat_val(rnd_shift(prod, 27 - FRAC_BITS), SIG_W));
					state_q <= ST_Y;
				end
				ST_Y: begin
					v = prod + (acc_t'(d1_q) <<< 14);
					y_q <= SIG_W'(sat_val(rnd_shift(v, 14), SIG_W));
					state_q <= ST_D1A;
				end
				ST_D1A: begin
					v = prod + (acc_t'(d2_q) <<< 14);
					d1_q <= DLY_W'(sat_val(rnd_shift(v, 14), DLY_W));
					state_q <= ST_D2A;
				end
				ST_D2A: begin
					part_q <= prod;
					state_q <= ST_D2B;
				end
				ST_D2B: begin
					v = part_q + prod;
					d2_q <= DLY_W'(sat_val(rnd_shift(v, 14), DLY_W));
					state_q <= ST_ENV;
				end
				ST_ENV: begin
					env_q <= SIG_W'(acc_t'({1'b0, env_q}) + rnd_shift(prod, 16));
					part_q <= e - t;
					state_q <= ST_MSL;
				end
				ST_MSL: begin
					lo_q <= prod;
					state_q <= ST_MSH;
				end
				ST_MSH: begin
					// 16 x 50 bit product from its two halves
					v = (prod <<< 24) + lo_q;
					m = t + rnd_shift(v, 16);
					if (m < 0) begin
						m = '0;
					end
					ms_q <= MS_W'(m);
					rem_q <= MS_W'(m);
					root_q <= '0;
					cnt_q <= 5'(ROOT_STEPS - 1);
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (!trial[MS_W+1]) begin
						rem_q <= trial[MS_W-1:0];
						root_q <= {root_q[ROOT_W-2:0], 1'b1};
					end else begin
						root_q <= {root_q[ROOT_W-2:0], 1'b0};
					end
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[verif/knock_bandpass_rms_detector_tb.sv]
`timescale 1ns / 1ps
module knock_bandpass_rms_detector_tb import kbrd_pkg::*; ();

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam longint SIG_HI = 64'sd8388607;
	localparam longint SIG_LO = -64'sd8388608;
	localparam longint DLY_HI = 64'sd2147483647;
	localparam longint DLY_LO = -64'sd2147483648;

	typedef struct packed {
		logic signed [SIG_W-1:0] bp;
		logic [OUT_W-1:0] env;
		logic [OUT_W-1:0] rms;
	} result_t;

	typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0] val;
		logic [11:0] sample;
		logic typed;
		logic signed [SIG_W-1:0] bp;
		logic [OUT_W-1:0] env;
		logic [OUT_W-1:0] rms;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [11:0] adc_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SIG_W-1:0] bandpass_sample;
	logic [OUT_W-1:0] envelope_level;
	logic [OUT_W-1:0] rms_level;

	knock_bandpass_rms_detector uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .adc_sample(adc_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.bandpass_sample(bandpass_sample), .envelope_level(envelope_level),
		.rms_level(rms_level)
	);

	always #1 clk = ~clk;

	// shadow registers and filter state
	logic [CFG_W-1:0] reg_val [0:6];
	longint bias_est, dly1, dly2, env_acc, ms_acc;
	result_t pending_results[$];
	int errors = 0;
	int stall_mode = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_cnt = 0;

	function automatic longint round_sh(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic filter_sample(input logic [11:0] s, output result_t r);
		longint x, c, y, d1, d2, ay, root, b0, a1, a2;
		x = longint'(s) <<< 16;
		b0 = longint'($signed(reg_val[REG_BP_B0]));
		a1 = longint'($signed(reg_val[REG_BP_A1]));
		a2 = longint'($signed(reg_val[REG_BP_A2]));
		bias_est += round_sh(longint'(reg_val[REG_BIAS_ALPHA]) * (x - bias_est), 16);
		c = clamp(round_sh((x - bias_est) * longint'(reg_val[REG_SIGNAL_GAIN]), 19),
			SIG_LO, SIG_HI);
		y = clamp(round_sh(b0 * c + dly1 * 16384, 14), SIG_LO, SIG_HI);
		d1 = clamp(round_sh(dly2 * 16384 - a1 * y, 14), DLY_LO, DLY_HI);
		d2 = clamp(round_sh(-b0 * c - a2 * y, 14), DLY_LO, DLY_HI);
		dly1 = d1;
		dly2 = d2;
		ay = y < 0 ? -y : y;
		env_acc += round_sh(longint'(reg_val[REG_ENV_ALPHA]) * (ay - env_acc), 16);
		ms_acc += round_sh(longint'(reg_val[REG_RMS_ALPHA]) * (y * y - ms_acc), 16);
		if (ms_acc < 0) begin
			ms_acc = 0;
		end
		ms_acc &= (longint'(1) <<< 48) - 1;
		root = 0;
		for (int b = 23; b >= 0; b--) begin
			if ((root | (longint'(1) <<< b)) * (root | (longint'(1) <<< b)) <= ms_acc) begin
				root |= longint'(1) <<< b;
			end
		end
		r.bp = y[SIG_W-1:0];
		r.env = env_acc > SIG_HI ? OUT_W'(SIG_HI) : env_acc[OUT_W-1:0];
		r.rms = root > SIG_HI ? OUT_W'(SIG_HI) : root[OUT_W-1:0];
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// receiver: checks results and stalls on its own pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report("unexpected result", bandpass_sample, 0);
				end else begin
					result_t w;
					w = pending_results.pop_front();
					if (bandpass_sample !== w.bp) report("bandpass_sample", bandpass_sample, w.bp);
					if (envelope_level !== w.env) report("envelope_level", envelope_level, w.env);
					if (rms_level !== w.rms) report("rms_level", rms_level, w.rms);
				end
			end
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					1: out_stall <= ($urandom_range(0, 9) < 3);
					2: out_stall <= (($urandom_range(0, 6)) < 3);
					3: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= 1'b0;
				endcase
			end
		end
	end

	// a one-cycle write strobe, then the write enable goes low before the task returns
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		if (idx != REG_SPARE) begin
			reg_val[idx] = d;
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// keeps valid high after acceptance, the caller lowers it for a gap
	task automatic send_sample(input logic [11:0] s, input logic typed, input result_t given);
		result_t r;
		in_valid <= 1'b1;
		adc_sample <= s;
		do @(posedge clk); while (in_stall);
		filter_sample(s, r);
		pending_results.push_back(typed ? given : r);
	endtask

	function automatic logic [11:0] pick_sample();
		case ($urandom_range(0, 3))
			0: return 12'($urandom_range(0, 4095));
			1: return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
			default: return 12'($urandom_range(1700, 2400));
		endcase
	endfunction

	row_t directed [] = '{
		'{ROW_SAMPLE, REG_BIAS_ALPHA, 16'd0, 12'd0, 1'b1, 24'sd0, 23'd0, 23'd0},
		'{ROW_SAMPLE, REG_BIAS_ALPHA, 16'd0, 12'd4095, 1'b1, 24'sd0, 23'd0, 23'd0},
		'{ROW_SAMPLE, REG_BIAS_ALPHA, 16'd0, 12'h800, 1'b1, 24'sd0, 23'd0, 23'd0},
		'{ROW_SAMPLE, REG_BIAS_ALPHA, 16'd0, 12'hAAA, 1'b1, 24'sd0, 23'd0, 23'd0},
		'{ROW_SAMPLE, REG_BIAS_ALPHA, 16'd0, 12'h555, 1'b1, 24'sd0, 23'd0, 23'd0},
		'{ROW_CFG, REG_SIGNAL_GAIN, 16'hFFFF, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_CFG, REG_BP_B0, 16'h7FFF, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_CFG, REG_BP_A1, 16'h8000, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_CFG, REG_BP_A2, 16'h7FFF, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_CFG, REG_BIAS_ALPHA, 16'hFFFF, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_CFG, REG_ENV_ALPHA, 16'hFFFF, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_CFG, REG_RMS_ALPHA, 16'hFFFF, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_CFG, REG_SPARE, 16'hFFFF, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_SAMPLE, REG_BIAS_ALPHA, 16'd0, 12'd4095, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_SAMPLE, REG_BIAS_ALPHA, 16'd0, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_SAMPLE, REG_BIAS_ALPHA, 16'd0, 12'd4095, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_SAMPLE, REG_BIAS_ALPHA, 16'd0, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_SAMPLE, REG_BIAS_ALPHA, 16'd0, 12'd4095, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_CFG, REG_BP_B0, 16'h8000, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_CFG, REG_BIAS_ALPHA, 16'h0000, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_CFG, REG_ENV_ALPHA, 16'h0000, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_CFG, REG_RMS_ALPHA, 16'h0000, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_SAMPLE, REG_BIAS_ALPHA, 16'd0, 12'd0, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_SAMPLE, REG_BIAS_ALPHA, 16'd0, 12'd4095, 1'b0, 24'sd0, 23'd0, 23'd0},
		'{ROW_SAMPLE, REG_BIAS_ALPHA, 16'd0, 12'h800, 1'b0, 24'sd0, 23'd0, 23'd0}
	};

	initial begin
		result_t none;
		int burst;
		none = '0;
		reg_val[REG_BIAS_ALPHA] = BIAS_ALPHA_RST;
		reg_val[REG_SIGNAL_GAIN] = SIGNAL_GAIN_RST;
		reg_val[REG_BP_B0] = '0;
		reg_val[REG_BP_A1] = '0;
		reg_val[REG_BP_A2] = '0;
		reg_val[REG_ENV_ALPHA] = ENV_ALPHA_RST;
		reg_val[REG_RMS_ALPHA] = RMS_ALPHA_RST;
		bias_est = 0;
		dly1 = 0;
		dly2 = 0;
		env_acc = 0;
		ms_acc = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				drain();
				write_reg(directed[i].idx, directed[i].val);
			end else begin
				send_sample(directed[i].sample, directed[i].typed,
					'{directed[i].bp, directed[i].env, directed[i].rms});
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end

		for (int ph = 0; ph < 5; ph++) begin
			drain();
			stall_mode = ph % 4;
			if (ph == 0) begin
				// a typical resonant bandpass
				write_reg(REG_BIAS_ALPHA, 16'd655);
				write_reg(REG_SIGNAL_GAIN, 16'd2048);
				write_reg(REG_BP_B0, 16'd1200);
				write_reg(REG_BP_A1, 16'hA000);
				write_reg(REG_BP_A2, 16'd14000);
				write_reg(REG_ENV_ALPHA, 16'd6554);
				write_reg(REG_RMS_ALPHA, 16'd3277);
			end else begin
				for (int k = 0; k < 7; k++) begin
					write_reg(k[CFG_IDX_W-1:0], $urandom_range(0, 3) == 0 ?
						($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) : 16'($urandom));
				end
			end
			if (ph == 1) begin
				hold_asks++;
			end
			for (int n = 0; n < 205; ) begin
				burst = $urandom_range(1, 8);
				for (int b = 0; b < burst; b++) begin
					send_sample(pick_sample(), 1'b0, none);
					n++;
				end
				if (n % 100 < burst) begin
					in_valid <= 1'b0;
					while (pending_results.size() != 0) @(posedge clk);
				end else if (ph != 2 && $urandom_range(0, 1)) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 25)) @(posedge clk);
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
